[hdl/ring_queue_with_front_insert_assert.svh]
// Assertion macros shared by the ring queue RTL.
`ifndef RING_QUEUE_WITH_FRONT_INSERT_ASSERT_SVH
`define RING_QUEUE_WITH_FRONT_INSERT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property at every rising clock edge outside reset.
`define RQFI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rqfi assertion failed");
// Check that a condition is followed in the next cycle by another.
`define RQFI_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rqfi assertion failed");
`else
`define RQFI_ASSERT(lbl, clk, rst_n, prop)
`define RQFI_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

[hdl/rqfi_pkg.sv]
// Types and constants for the ring queue with front insert.
`default_nettype none
package rqfi_pkg;

  localparam int unsigned PORT_WORD_BITS = 32;
  localparam int unsigned FILL_BITS      = 5;

  typedef enum logic [1:0] {
    CMD_PUT       = 2'd0,
    CMD_PUT_FRONT = 2'd1,
    CMD_GET       = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DISABLED = 3'd1,
    ST_FULL_ADJ = 3'd2,
    ST_FULL_CNT = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

endpackage
`default_nettype wire

[hdl/rqfi_mem.sv]
// Slot store: one write port, one registered read port with write-first bypass.
`default_nettype none
module rqfi_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Return the word being written when both ports hit the same slot.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hdl/ring_queue_with_front_insert.sv]
// Top level of the ring queue with front insert.
//
// Takes one command in every clock cycle: busy never rises, so a command is
// taken at each edge where start is high. Its result appears on the result
// ports in the next cycle, marked by done_o for exactly one cycle; the receiver
// cannot stall it. One command per cycle rests on head, tail and count being
// updated together in the same cycle and on the one registered read
// port of the slot store, which keeps the word behind the head fetched ahead
// so that back-to-back gets find it ready. The slot store needs no clearing
// pass after reset: only words from slots inside the occupied region are used.
`default_nettype none
`include "ring_queue_with_front_insert_assert.svh"
module ring_queue_with_front_insert
  import rqfi_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // command channel
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                cmd_i,
  input  wire logic [PORT_WORD_BITS-1:0] put_word_i,
  // result channel
  output logic                           done_o,
  output logic [2:0]                     status_o,
  output logic [PORT_WORD_BITS-1:0]      got_word_o,
  output logic [PORT_WORD_BITS-1:0]      head_word_o,
  output logic [FILL_BITS-1:0]           fill_count_o,
  output logic                           can_accept_o,
  // configuration channel
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic                      cfg_wdata_i
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = (WORD_BITS < PORT_WORD_BITS) ? WORD_BITS : PORT_WORD_BITS;

  logic          enabled_q;
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [SW-1:0] front_q, front_d;

  logic          accept;
  logic          we;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;
  logic [SW-1:0] word;
  logic [SW-1:0] next_word;
  logic [SW-1:0] got;
  logic [SW-1:0] peek;
  status_e       status;
  logic          can_accept;

  logic [SW+PORT_WORD_BITS-1:0] got_ext;
  logic [SW+PORT_WORD_BITS-1:0] peek_ext;
  logic [CW+FILL_BITS-1:0]      count_ext;

  logic                      done_q;
  status_e                   status_q;
  logic [PORT_WORD_BITS-1:0] got_q;
  logic [PORT_WORD_BITS-1:0] peek_q;
  logic [FILL_BITS-1:0]      fill_q;
  logic                      can_q;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] x);
    return (x == IW'(DEPTH - 1)) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] x);
    return (x == '0) ? IW'(DEPTH - 1) : x - 1'b1;
  endfunction

  // Tail-plus-one against head is compared without wrap.
  function automatic status_e put_check(input logic          en,
                                        input logic [IW-1:0] h,
                                        input logic [IW-1:0] t,
                                        input logic [CW-1:0] c);
    status_e st;
    if (!en) begin
      st = ST_DISABLED;
    end else if (({1'b0, t} + (IW+1)'(1)) == {1'b0, h}) begin
      st = ST_FULL_ADJ;
    end else if (c == CW'(DEPTH)) begin
      st = ST_FULL_CNT;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign word        = put_word_i[SW-1:0];

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    front_d = front_q;
    we      = 1'b0;
    waddr   = tail_q;
    status  = ST_OK;
    got     = '0;
    if (accept) begin
      case (cmd_e'(cmd_i))
        CMD_PUT: begin
          status = put_check(enabled_q, head_q, tail_q, count_q);
          if (status == ST_OK) begin
            we      = 1'b1;
            waddr   = tail_q;
            tail_d  = idx_inc(tail_q);
            count_d = count_q + 1'b1;
            // an empty queue has head on tail: the new word is the front
            if (count_q == '0) begin
              front_d = word;
            end
          end
        end
        CMD_PUT_FRONT: begin
          status = put_check(enabled_q, head_q, tail_q, count_q);
          if (status == ST_OK) begin
            head_d  = idx_dec(head_q);
            we      = 1'b1;
            waddr   = idx_dec(head_q);
            front_d = word;
            count_d = count_q + 1'b1;
          end
        end
        CMD_GET: begin
          if (!enabled_q || (count_q == '0)) begin
            status = ST_EMPTY;
          end else begin
            got     = front_q;
            head_d  = idx_inc(head_q);
            front_d = next_word;
            count_d = count_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Keep the word behind the new head fetched for the next get.
  assign raddr = idx_inc(head_d);

  assign peek       = (count_d == '0) ? '0 : front_d;
  assign can_accept = (put_check(enabled_q, head_d, tail_d, count_d) == ST_OK);

  assign got_ext   = {{PORT_WORD_BITS{1'b0}}, got};
  assign peek_ext  = {{PORT_WORD_BITS{1'b0}}, peek};
  assign count_ext = {{FILL_BITS{1'b0}}, count_d};

  rqfi_mem #(
    .DEPTH (DEPTH),
    .WIDTH (SW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (word),
    .raddr_i (raddr),
    .rdata_o (next_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b1;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        enabled_q <= cfg_wdata_i;
      end
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    if (accept) begin
      status_q <= status;
      got_q    <= got_ext[PORT_WORD_BITS-1:0];
      peek_q   <= peek_ext[PORT_WORD_BITS-1:0];
      fill_q   <= count_ext[FILL_BITS-1:0];
      can_q    <= can_accept;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign got_word_o   = got_q;
  assign head_word_o  = peek_q;
  assign fill_count_o = fill_q;
  assign can_accept_o = can_q;

  `RQFI_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH))
  `RQFI_ASSERT(a_empty_aligned, clk_i, rst_ni, (count_q == '0) |-> (head_q == tail_q))
  `RQFI_ASSERT(a_count_step, clk_i, rst_ni, (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) || (count_q + 1'b1 == $past(count_q)))
  `RQFI_ASSERT_NEXT(a_done_follows, clk_i, rst_ni, accept, done_o)
  `RQFI_ASSERT(a_empty_peek, clk_i, rst_ni, (done_o && (fill_count_o == '0) && (DEPTH < 32)) |-> (head_word_o == '0))

endmodule
`default_nettype wire

[tb/sv/tb_ring_queue_with_front_insert.sv]
// Self-checking testbench for the ring queue with front insert: directed and random commands.
module tb_ring_queue_with_front_insert;
  import rqfi_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam logic [1:0]  CMD_NONE    = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    status_e     status;
    logic [31:0] got_word;
    logic [31:0] head_word;
    logic [4:0]  fill;
    logic        can_accept;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  cmd_i;
  logic [31:0] put_word_i;
  logic        done_o;
  logic [2:0]  status_o;
  logic [31:0] got_word_o;
  logic [31:0] head_word_o;
  logic [4:0]  fill_count_o;
  logic        can_accept_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_wdata_i;

  // shadow copy of the queue
  logic [31:0] slot_model [DEPTH];
  int unsigned head_ptr;
  int unsigned tail_ptr;
  int unsigned fill_model;
  logic        queue_open;

  outcome_t    pending_results [$];
  int unsigned status_seen [5];
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned cfg_writes;
  bit          idling;

  ring_queue_with_front_insert #(
    .DEPTH    (DEPTH),
    .WORD_BITS(32)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .put_word_i  (put_word_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .got_word_o  (got_word_o),
    .head_word_o (head_word_o),
    .fill_count_o(fill_count_o),
    .can_accept_o(can_accept_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void model_reset();
    for (int i = 0; i < DEPTH; i++) slot_model[i] = '0;
    head_ptr   = 0;
    tail_ptr   = 0;
    fill_model = 0;
    queue_open = 1'b1;
  endfunction

  // The adjacency test compares plain indices, so it does not see the wrap from 15 to 0.
  function automatic status_e put_verdict();
    if (!queue_open) return ST_DISABLED;
    if (tail_ptr + 1 == head_ptr) return ST_FULL_ADJ;
    if (fill_model == DEPTH) return ST_FULL_CNT;
    return ST_OK;
  endfunction

  function automatic outcome_t apply_command(logic [1:0] c, logic [31:0] w);
    outcome_t r;
    r.status   = ST_OK;
    r.got_word = '0;
    if (c == CMD_PUT || c == CMD_PUT_FRONT) begin
      r.status = put_verdict();
      if (r.status == ST_OK) begin
        if (c == CMD_PUT_FRONT) begin
          head_ptr = (head_ptr == 0) ? DEPTH - 1 : head_ptr - 1;
          slot_model[head_ptr] = w;
        end else begin
          slot_model[tail_ptr] = w;
          tail_ptr = (tail_ptr + 1 >= DEPTH) ? 0 : tail_ptr + 1;
        end
        fill_model++;
      end
    end else if (c == CMD_GET) begin
      if (!queue_open || fill_model == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.got_word = slot_model[head_ptr];
        slot_model[head_ptr] = '0;
        head_ptr = (head_ptr + 1 >= DEPTH) ? 0 : head_ptr + 1;
        fill_model--;
      end
    end
    r.head_word  = slot_model[head_ptr];
    r.fill       = fill_model[4:0];
    r.can_accept = (put_verdict() == ST_OK);
    return r;
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] seen);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, want, seen);
  endfunction

  function automatic void compare_field(string what, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) note_mismatch(what, want, seen);
  endfunction

  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with none pending", '0, {29'd0, status_o});
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 32'(want.status), 32'(status_o));
        compare_field("got_word", want.got_word, got_word_o);
        compare_field("head_word", want.head_word, head_word_o);
        compare_field("fill_count", 32'(want.fill), 32'(fill_count_o));
        compare_field("can_accept", 32'(want.can_accept), 32'(can_accept_o));
        results_checked++;
      end
    end
  end

  // Hold the word until it is taken, then predict its result.
  task automatic issue_cmd(input logic [1:0] c, input logic [31:0] w, output status_e st);
    outcome_t r;
    start      <= 1'b1;
    cmd_i      <= c;
    put_word_i <= w;
    do @(posedge clk_i); while (busy !== 1'b0);
    r = apply_command(c, w);
    pending_results.push_back(r);
    status_seen[r.status]++;
    st = r.status;
  endtask

  task automatic sender_pause();
    if (idling && $urandom_range(0, 3) == 0) begin
      start      <= 1'b0;
      cmd_i      <= 2'($urandom);
      put_word_i <= $urandom;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Drain all results before touching the register.
  task automatic write_enable(input logic v);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    queue_open = v;
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic test_reset_state();
    status_e st;
    issue_cmd(CMD_GET, 32'hFFFF_FFFF, st);
    issue_cmd(CMD_NONE, 32'hFFFF_FFFF, st);
  endtask

  task automatic test_extremes();
    status_e st;
    issue_cmd(CMD_PUT, 32'h0000_0000, st);
    sender_pause();
    issue_cmd(CMD_PUT, 32'hFFFF_FFFF, st);
    // head at 0 here, so the front insert wraps it to the top slot
    issue_cmd(CMD_PUT_FRONT, 32'h0000_0000, st);
    issue_cmd(CMD_PUT_FRONT, 32'hFFFF_FFFF, st);
    sender_pause();
    issue_cmd(CMD_NONE, 32'h1234_5678, st);
    repeat (5) begin
      issue_cmd(CMD_GET, $urandom, st);
      sender_pause();
    end
  endtask

  task automatic test_disabled();
    status_e st;
    issue_cmd(CMD_PUT, 32'hA5A5_5A5A, st);
    write_enable(1'b0);
    issue_cmd(CMD_PUT, 32'h5A5A_A5A5, st);
    issue_cmd(CMD_PUT_FRONT, 32'hDEAD_BEEF, st);
    issue_cmd(CMD_GET, 32'h0, st);
    issue_cmd(CMD_NONE, 32'hFFFF_FFFF, st);
    write_enable(1'b1);
    issue_cmd(CMD_GET, 32'h0, st);
  endtask

  // Fill until refused, then drain. Even rounds start with head at 0 so the count reaches DEPTH;
  // odd rounds start elsewhere and mix front inserts, which can end on the adjacency refusal.
  task automatic test_fill_drain();
    int unsigned steps;
    int unsigned refusals;
    int unsigned attempts;
    logic [1:0]  c;
    status_e     st;
    for (int round = 0; round < 4; round++) begin
      steps = (round % 2 == 0) ? (DEPTH - head_ptr) % DEPTH : $urandom_range(1, DEPTH - 1);
      repeat (steps) begin
        issue_cmd(CMD_PUT, $urandom, st);
        issue_cmd(CMD_GET, $urandom, st);
        sender_pause();
      end
      refusals = 0;
      attempts = 0;
      while (refusals < 3 && attempts < 40) begin
        if (round % 2 == 0 && refusals == 0) c = CMD_PUT;
        else c = ($urandom_range(0, 1) == 0) ? CMD_PUT : CMD_PUT_FRONT;
        issue_cmd(c, $urandom, st);
        if (st != ST_OK) refusals++;
        attempts++;
        sender_pause();
      end
      do begin
        issue_cmd(CMD_GET, $urandom, st);
        sender_pause();
      end while (st != ST_EMPTY);
    end
  endtask

  function automatic logic [1:0] pick_cmd(int unsigned put_share);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return CMD_NONE;
    if (r < 3 + put_share) return ($urandom_range(0, 2) == 0) ? CMD_PUT_FRONT : CMD_PUT;
    return CMD_GET;
  endfunction

  task automatic test_random_mix();
    int unsigned put_share;
    status_e     st;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 3) write_enable(1'b0);
      if (phase == 4) write_enable(1'b1);
      idling = ($urandom_range(0, 2) != 0);
      case (phase % 3)
        0: put_share = 70;
        1: put_share = 30;
        default: put_share = 50;
      endcase
      repeat (20) begin
        issue_cmd(pick_cmd(put_share), $urandom, st);
        sender_pause();
      end
    end
    idling = 1'b1;
  endtask

  // Back-to-back words only: full run of puts, full run of gets, then a random mix.
  task automatic test_back_to_back();
    status_e st;
    idling = 1'b0;
    repeat (18) issue_cmd(CMD_PUT, $urandom, st);
    repeat (18) issue_cmd(CMD_GET, $urandom, st);
    repeat (40) issue_cmd(pick_cmd(50), $urandom, st);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = '0;
    put_word_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_wdata_i = 1'b0;
    idling      = 1'b1;
    model_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_extremes();
    test_disabled();
    test_fill_drain();
    test_random_mix();
    test_back_to_back();

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("checked %0d results: %0d ok, %0d disabled, %0d full by index, %0d full by count",
             results_checked, status_seen[ST_OK], status_seen[ST_DISABLED],
             status_seen[ST_FULL_ADJ], status_seen[ST_FULL_CNT]);
    $display("%0d empty gets, %0d register writes, %0d mismatches",
             status_seen[ST_EMPTY], cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
